### rtl/dfcb_pkg.sv
// package for the duty frame builder: frame positions, register indexes,
// crc-16/arc column table and the crc low-byte rewrite function
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dfcb_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned DUTY_W    = 11;
    localparam int unsigned PAT_W     = 32;
    localparam int unsigned CRC_W     = 16;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned POS_W     = 4;

    localparam logic [CRC_W-1:0] CRC_POLY  = 16'hA001;
    localparam logic [8:0]       LOW_ADD   = 9'd96;
    localparam logic [8:0]       LOW_LIMIT = 9'd127;

    localparam logic signed [DUTY_W-1:0] DUTY_MAX = 11'sd1000;
    localparam logic signed [DUTY_W-1:0] DUTY_MIN = -11'sd1000;

    localparam logic [BYTE_W-1:0] RST_START   = 8'd170;
    localparam logic [BYTE_W-1:0] RST_LENGTH  = 8'd5;
    localparam logic [BYTE_W-1:0] RST_COMMAND = 8'd3;
    localparam logic [BYTE_W-1:0] RST_END     = 8'd221;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END     = 8'd3;

    // frame byte positions
    localparam logic [POS_W-1:0] POS_START   = 4'd0;
    localparam logic [POS_W-1:0] POS_LENGTH  = 4'd1;
    localparam logic [POS_W-1:0] POS_COMMAND = 4'd2;
    localparam logic [POS_W-1:0] POS_PAY0    = 4'd3;
    localparam logic [POS_W-1:0] POS_PAY1    = 4'd4;
    localparam logic [POS_W-1:0] POS_PAY2    = 4'd5;
    localparam logic [POS_W-1:0] POS_PAY3    = 4'd6;
    localparam logic [POS_W-1:0] POS_CRC_HI  = 4'd7;
    localparam logic [POS_W-1:0] POS_CRC_LO  = 4'd8;
    localparam logic [POS_W-1:0] POS_END     = 4'd9;

    typedef logic [CRC_W-1:0] t_crc_cols [0:PAT_W-1];

    // crc of a payload with a single bit set, one column per payload bit
    function automatic t_crc_cols crc_cols_init();
        t_crc_cols        cols;
        logic [PAT_W-1:0] pat;
        logic [CRC_W-1:0] c;
        for (int j = 0; j < PAT_W; j++) begin
            pat = '0;
            pat[j] = 1'b1;
            c = '0;
            for (int k = 0; k < 4; k++) begin
                c = c ^ {8'h00, pat[PAT_W-1-8*k -: 8]};
                for (int b = 0; b < 8; b++) begin
                    if (c[0]) begin
                        c = (c >> 1) ^ CRC_POLY;
                    end else begin
                        c = c >> 1;
                    end
                end
            end
            cols[j] = c;
        end
        return cols;
    endfunction

    localparam t_crc_cols CRC_COLS = crc_cols_init();

    function automatic logic [BYTE_W-1:0] fix_low(input logic [BYTE_W-1:0] low);
        logic [8:0] s;
        s = {1'b0, low} + LOW_ADD;
        if (s > LOW_LIMIT) begin
            if (s[7] && s[5]) begin
                s[7] = 1'b0;
            end else if (s[7] && s[6]) begin
                s[7:6] = 2'b00;
            end else begin
                s[7] = 1'b0;
                s[6] = 1'b1;
            end
        end
        return s[BYTE_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/duty_frame_crc16_builder_top.sv
// duty frame builder: saturated duty payload, crc-16/arc with low-byte
// rewrite, ten-byte frame serializer; depends on dfcb_pkg
//
// channel | direction | handshake                | payload
// in      | input     | i_in_valid / o_in_stall  | i_duty_milli
// out     | output    | o_out_valid / i_out_stall| o_frame_byte, o_last_byte
// cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// an item is held in an input register; crc and payload are formed
// combinationally and loaded into the frame register, which then sends
// ten bytes, one per cycle unless out stall holds; the input register takes
// the next item while the current frame is still being sent.
// out stall holds the current byte; synchronous active-low reset clears
// control state and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module duty_frame_crc16_builder_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic signed [dfcb_pkg::DUTY_W-1:0] i_duty_milli,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [dfcb_pkg::BYTE_W-1:0]            o_frame_byte,
    output logic                                   o_last_byte,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [dfcb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [dfcb_pkg::BYTE_W-1:0]       i_cfg_data
);
    import dfcb_pkg::*;

    logic [BYTE_W-1:0] r_start;
    logic [BYTE_W-1:0] r_length;
    logic [BYTE_W-1:0] r_command;
    logic [BYTE_W-1:0] r_end;

    logic                     r_in_valid;
    logic signed [DUTY_W-1:0] r_duty;

    logic              r_busy;
    logic [POS_W-1:0]  r_pos;
    logic [PAT_W-1:0]  r_pat;
    logic [CRC_W-1:0]  r_crc;

    logic signed [DUTY_W-1:0] n_duty_sat;
    logic [PAT_W-1:0]         n_pat;
    logic [CRC_W-1:0]         n_crc;

    logic w_out_adv;
    logic w_last;
    logic w_load;
    logic w_in_acc;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= RST_START;
            r_length  <= RST_LENGTH;
            r_command <= RST_COMMAND;
            r_end     <= RST_END;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_START:   r_start   <= i_cfg_data;
                CFG_LENGTH:  r_length  <= i_cfg_data;
                CFG_COMMAND: r_command <= i_cfg_data;
                CFG_END:     r_end     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake control
    assign w_out_adv  = r_busy && !i_out_stall;
    assign w_last     = (r_pos == POS_END);
    assign w_load     = r_in_valid && (!r_busy || (w_out_adv && w_last));
    assign o_in_stall = r_in_valid && !w_load;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_duty <= i_duty_milli;
        end
    end

    // saturate, sign-extend and crc
    always_comb begin
        if (r_duty > DUTY_MAX) begin
            n_duty_sat = DUTY_MAX;
        end else if (r_duty < DUTY_MIN) begin
            n_duty_sat = DUTY_MIN;
        end else begin
            n_duty_sat = r_duty;
        end
        n_pat = {{(PAT_W-DUTY_W){n_duty_sat[DUTY_W-1]}}, n_duty_sat};
        n_crc = '0;
        for (int j = 0; j < PAT_W; j++) begin
            if (n_pat[j]) begin
                n_crc = n_crc ^ CRC_COLS[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pat <= n_pat;
            r_crc <= {n_crc[CRC_W-1:BYTE_W], fix_low(n_crc[BYTE_W-1:0])};
        end
    end

    // frame serializer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= POS_START;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_pos  <= POS_START;
        end else if (w_out_adv) begin
            if (w_last) begin
                r_busy <= 1'b0;
                r_pos  <= POS_START;
            end else begin
                r_pos <= r_pos + 4'd1;
            end
        end
    end

    assign o_out_valid = r_busy;
    assign o_last_byte = w_last;

    always_comb begin
        case (r_pos)
            POS_START:   o_frame_byte = r_start;
            POS_LENGTH:  o_frame_byte = r_length;
            POS_COMMAND: o_frame_byte = r_command;
            POS_PAY0:    o_frame_byte = r_pat[31:24];
            POS_PAY1:    o_frame_byte = r_pat[23:16];
            POS_PAY2:    o_frame_byte = r_pat[15:8];
            POS_PAY3:    o_frame_byte = r_pat[7:0];
            POS_CRC_HI:  o_frame_byte = r_crc[15:8];
            POS_CRC_LO:  o_frame_byte = r_crc[7:0];
            POS_END:     o_frame_byte = r_end;
            default:     o_frame_byte = r_end;
        endcase
    end

endmodule

`default_nettype wire

### bench/duty_frame_crc16_builder_top_tb.sv
// self-checking bench for duty_frame_crc16_builder_top: a directed table, then
// random duty values across several register settings and idling patterns
// depends on dfcb_pkg and the rtl top level
`timescale 1ns / 1ps

module duty_frame_crc16_builder_top_tb;
    import dfcb_pkg::*;

    localparam int FRAME_BYTES   = 10;
    localparam int DUTY_LIMIT    = 1000;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 76;
    localparam int MAX_PRINTED   = 100;
    localparam logic [15:0] ARC_POLY = 16'hA001;

    typedef logic [BYTE_W-1:0] t_frame [FRAME_BYTES];

    typedef struct {
        logic [BYTE_W-1:0] fbyte;
        logic              fin;
    } t_frame_byte;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              typed;
        logic [PAT_W-1:0]  pat;
    } t_duty_row;

    typedef enum int {
        LOW_KEPT  = 0,
        LOW_CLR7  = 1,
        LOW_CLR76 = 2,
        LOW_SET6  = 3
    } t_low_rule;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic signed [DUTY_W-1:0]   duty      = '0;
    logic                       out_stall = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [BYTE_W-1:0]          cfg_data  = '0;

    logic                       in_stall;
    logic                       out_valid;
    logic [BYTE_W-1:0]          frame_byte;
    logic                       last_byte;
    logic                       cfg_ready;

    logic [BYTE_W-1:0] cfg_start   = RST_START;
    logic [BYTE_W-1:0] cfg_length  = RST_LENGTH;
    logic [BYTE_W-1:0] cfg_command = RST_COMMAND;
    logic [BYTE_W-1:0] cfg_end     = RST_END;

    t_frame_byte pending_bytes [$];
    int mismatches     = 0;
    int frames_sent    = 0;
    int frames_checked = 0;
    int clipped_items  = 0;
    int reg_writes     = 0;
    int rule_hits [4]  = '{0, 0, 0, 0};
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    t_duty_row directed [21] = '{
        '{11'h400, 1'b1, 32'hFFFF_FC18},
        '{11'h417, 1'b1, 32'hFFFF_FC18},
        '{11'h418, 1'b1, 32'hFFFF_FC18},
        '{11'h419, 1'b1, 32'hFFFF_FC19},
        '{11'h7FF, 1'b1, 32'hFFFF_FFFF},
        '{11'h000, 1'b1, 32'h0000_0000},
        '{11'h001, 1'b1, 32'h0000_0001},
        '{11'h3E7, 1'b1, 32'h0000_03E7},
        '{11'h3E8, 1'b1, 32'h0000_03E8},
        '{11'h3E9, 1'b1, 32'h0000_03E8},
        '{11'h3FF, 1'b1, 32'h0000_03E8},
        '{11'h155, 1'b0, 32'h0},
        '{11'h2AA, 1'b0, 32'h0},
        '{11'h200, 1'b0, 32'h0},
        '{11'h600, 1'b0, 32'h0},
        '{11'h0FF, 1'b0, 32'h0},
        '{11'h100, 1'b0, 32'h0},
        '{11'h700, 1'b0, 32'h0},
        '{11'h007, 1'b0, 32'h0},
        '{11'h7F8, 1'b0, 32'h0},
        '{11'h064, 1'b0, 32'h0}
    };

    duty_frame_crc16_builder_top dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_duty_milli (duty),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_frame_byte (frame_byte),
        .o_last_byte  (last_byte),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    // expected frame for one duty value under the current register mirror
    function automatic t_frame duty_frame_bytes(input logic signed [DUTY_W-1:0] d,
                                                output t_low_rule rule,
                                                output bit clipped);
        t_frame      f;
        int          v;
        logic [31:0] word;
        logic [15:0] crc;
        logic        fb;
        logic [8:0]  s;
        v = d;
        clipped = 1'b0;
        if (v > DUTY_LIMIT) begin
            v = DUTY_LIMIT;
            clipped = 1'b1;
        end
        if (v < -DUTY_LIMIT) begin
            v = -DUTY_LIMIT;
            clipped = 1'b1;
        end
        word = v;
        // reflected crc, bytes taken msb first, bits within a byte lsb first
        crc = '0;
        for (int i = 0; i < 32; i++) begin
            fb = crc[0] ^ word[24 - 8 * (i / 8) + (i % 8)];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ ARC_POLY;
            end
        end
        s = {1'b0, crc[7:0]} + 9'd96;
        rule = LOW_KEPT;
        if (s > 9'd127) begin
            if (s[7] && s[5]) begin
                s[7] = 1'b0;
                rule = LOW_CLR7;
            end else if (s[7] && s[6]) begin
                s[7:6] = 2'b00;
                rule = LOW_CLR76;
            end else begin
                s[7] = 1'b0;
                s[6] = 1'b1;
                rule = LOW_SET6;
            end
        end
        f[POS_START]   = cfg_start;
        f[POS_LENGTH]  = cfg_length;
        f[POS_COMMAND] = cfg_command;
        {f[POS_PAY0], f[POS_PAY1], f[POS_PAY2], f[POS_PAY3]} = word;
        f[POS_CRC_HI]  = crc[15:8];
        f[POS_CRC_LO]  = s[7:0];
        f[POS_END]     = cfg_end;
        return f;
    endfunction

    task automatic send_duty(input logic signed [DUTY_W-1:0] d, input bit typed,
                             input logic [PAT_W-1:0] pat);
        t_frame    f;
        t_low_rule rule;
        bit        clipped;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        duty <= d;
        do @(posedge clk); while (in_stall);
        f = duty_frame_bytes(d, rule, clipped);
        if (typed) begin
            {f[POS_PAY0], f[POS_PAY1], f[POS_PAY2], f[POS_PAY3]} = pat;
        end
        for (int k = 0; k < FRAME_BYTES; k++) begin
            pending_bytes.push_back('{f[k], k == FRAME_BYTES - 1});
        end
        frames_sent++;
        rule_hits[int'(rule)]++;
        if (clipped) begin
            clipped_items++;
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic load_regs(input logic [BYTE_W-1:0] v_start, input logic [BYTE_W-1:0] v_len,
                             input logic [BYTE_W-1:0] v_cmd, input logic [BYTE_W-1:0] v_end,
                             input logic [CFG_IDX_W-1:0] junk_idx,
                             input logic [BYTE_W-1:0] junk_val);
        logic [CFG_IDX_W-1:0] idx [5];
        logic [BYTE_W-1:0]    val [5];
        idx = '{CFG_START, CFG_LENGTH, CFG_COMMAND, CFG_END, junk_idx};
        val = '{v_start, v_len, v_cmd, v_end, junk_val};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
            case (idx[i])
                CFG_START:   cfg_start = val[i];
                CFG_LENGTH:  cfg_length = val[i];
                CFG_COMMAND: cfg_command = val[i];
                CFG_END:     cfg_end = val[i];
                default:     ;
            endcase
            reg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [DUTY_W-1:0] random_duty();
        int v;
        case ($urandom_range(9))
            0:       v = $urandom_range(1023, 990);
            1:       v = -int'($urandom_range(1024, 990));
            default: v = int'($urandom_range(2047)) - 1024;
        endcase
        return v[DUTY_W-1:0];
    endfunction

    always @(posedge clk) begin
        t_frame_byte want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_bytes.size() == 0) begin
                flag_mismatch($sformatf("unexpected byte %02h last %b", frame_byte, last_byte));
            end else begin
                want = pending_bytes.pop_front();
                if (frame_byte !== want.fbyte) begin
                    flag_mismatch($sformatf("frame byte %02h, expected %02h",
                                            frame_byte, want.fbyte));
                end
                if (last_byte !== want.fin) begin
                    flag_mismatch($sformatf("last flag %b, expected %b", last_byte, want.fin));
                end
                if (want.fin) begin
                    frames_checked++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct  = 32;
        recv_stall_pct = 60;
        foreach (directed[i]) begin
            send_duty(directed[i].duty, directed[i].typed, directed[i].pat);
        end
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                1: load_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'd4, 8'($urandom_range(255)));
                2: load_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00);
                4: load_regs(RST_START, RST_LENGTH, RST_COMMAND, RST_END,
                             8'($urandom_range(255, 4)), 8'hFF);
                default: load_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                                   8'($urandom_range(255)), 8'($urandom_range(255)),
                                   8'($urandom_range(255, 4)), 8'($urandom_range(255)));
            endcase
            if (ph < 2) begin
                send_idle_pct  = 32;
                recv_stall_pct = 60;
            end else if (ph < 4) begin
                send_idle_pct  = 60;
                recv_stall_pct = 32;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off mid phase until the output side has drained
                if (n == PHASE_ITEMS / 2) begin
                    settle();
                end
                send_duty(random_duty(), 1'b0, '0);
            end
        end
        settle();
        repeat (3 * FRAME_BYTES) @(posedge clk);
        $display("%0d frames sent, %0d checked, %0d duty values clipped, %0d register writes",
                 frames_sent, frames_checked, clipped_items, reg_writes);
        $display("crc low byte rules: kept %0d, bit7 cleared %0d, bits 7:6 cleared %0d, %s %0d",
                 rule_hits[LOW_KEPT], rule_hits[LOW_CLR7], rule_hits[LOW_CLR76],
                 "bit6 forced", rule_hits[LOW_SET6]);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
